// ===== rtl/core/gutpc_pkg.sv =====
package gutpc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_GAINS_ID   = 3'd0;
    localparam logic [2:0] CFG_COMMIT_ID  = 3'd1;
    localparam logic [2:0] CFG_VERSION    = 3'd2;
    localparam logic [2:0] CFG_COOKIE     = 3'd3;
    localparam logic [2:0] CFG_MAX_GAIN   = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd5;

    // register reset values
    localparam logic [10:0] RST_GAINS_ID  = 11'd0;
    localparam logic [10:0] RST_COMMIT_ID = 11'd1;
    localparam logic [7:0]  RST_VERSION   = 8'd1;
    localparam logic [15:0] RST_COOKIE    = 16'd0;
    localparam logic [15:0] RST_MAX_GAIN  = 16'hFFFF;
    localparam logic [15:0] RST_TIMEOUT   = 16'd10;

    // frame layout
    localparam logic [3:0] FRAME_LEN = 4'd8;
    localparam logic [7:0] AXIS_LEFT  = 8'd1;
    localparam logic [7:0] AXIS_RIGHT = 8'd2;
    localparam logic [7:0] AXIS_BOTH  = 8'd3;

    // gains after reset, 0.20 / 0.60 / 0 in unsigned q8.8
    localparam logic [15:0] RST_KP = 16'd51;
    localparam logic [15:0] RST_KI = 16'd154;
    localparam logic [15:0] RST_KD = 16'd0;

    localparam int unsigned DATA_W = 120;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_FORMAT  = 3'd2,
        ST_UNSAFE  = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    typedef struct packed {
        logic [10:0] gains_id;
        logic [10:0] commit_id;
        logic [7:0]  version;
        logic [15:0] cookie;
        logic [15:0] max_gain;
        logic [15:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic        extended_flag;
        logic        remote_flag;
        logic [63:0] frame_bytes;
        logic [31:0] time_ms;
        logic        motion_cmd_fresh;
        logic        motion_cmd_stop;
        logic        motion_cmd_zero;
        logic        estop;
        logic        fault;
    } t_frame;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } t_gain_set;

    typedef struct packed {
        t_status     status;
        logic [15:0] sequence_no;
        logic [1:0]  axes;
        t_gain_set   left;
        t_gain_set   right;
    } t_result;

endpackage

// ===== rtl/core/gain_update_two_phase_commit_top.sv =====
// a request goes from the input register through the engine to the output register
// throughput: one request per cycle; staged entry and gain sets update as a request advances
// the input register stalls only while the output register holds an untaken result
// reset (synchronous, active low) empties both registers, restores the configuration
// defaults, clears the staged entry and sets both gain sets to kp 51, ki 154, kd 0
module gain_update_two_phase_commit_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // frame_id, frame_length, extended_flag, remote_flag, frame_bytes, time_ms,
    // motion_cmd_fresh, motion_cmd_stop, motion_cmd_zero, estop, fault
    input  logic [gutpc_pkg::DATA_W-1:0]   i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status_code, reply_sequence, reply_axes, left_kp, left_ki, left_kd,
    // right_kp, right_ki, right_kd
    output logic [gutpc_pkg::DATA_W-1:0]   o_m_axis_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [2:0]                     i_cfg_wr_idx,
    input  logic [15:0]                    i_cfg_wr_data
);

    gutpc_pkg::t_cfg     w_cfg;
    gutpc_pkg::t_frame   w_frame;
    gutpc_pkg::t_frame   r_in_frame;
    gutpc_pkg::t_result  w_result;
    logic                r_in_valid;
    logic                r_out_valid;
    logic [gutpc_pkg::DATA_W-1:0] r_out_data;
    logic                w_adv;
    logic                w_in_ready;

    gutpc_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_idx  (i_cfg_wr_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    // unpack input request
    always_comb begin
        w_frame.frame_id         = i_s_axis_tdata[10:0];
        w_frame.frame_length     = i_s_axis_tdata[14:11];
        w_frame.extended_flag    = i_s_axis_tdata[15];
        w_frame.remote_flag      = i_s_axis_tdata[16];
        w_frame.frame_bytes      = i_s_axis_tdata[80:17];
        w_frame.time_ms          = i_s_axis_tdata[112:81];
        w_frame.motion_cmd_fresh = i_s_axis_tdata[113];
        w_frame.motion_cmd_stop  = i_s_axis_tdata[114];
        w_frame.motion_cmd_zero  = i_s_axis_tdata[115];
        w_frame.estop            = i_s_axis_tdata[116];
        w_frame.fault            = i_s_axis_tdata[117];
    end

    // pipeline control
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign w_in_ready = !r_in_valid || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_s_axis_tvalid) begin
            r_in_frame <= w_frame;
        end
    end

    gutpc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_adv),
        .i_frame  (r_in_frame),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {3'd0,
                           w_result.right.kd, w_result.right.ki, w_result.right.kp,
                           w_result.left.kd, w_result.left.ki, w_result.left.kp,
                           w_result.axes, w_result.sequence_no, w_result.status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_data == $past(r_out_data))
        else $error("output register overwritten while stalled");

    a_adv_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result lost after advance");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && r_in_frame == $past(r_in_frame))
        else $error("pending request dropped");
`endif

endmodule

// ===== rtl/core/gutpc_cfg_regs.sv =====
module gutpc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_wr_idx,
    input  logic [15:0]         i_cfg_wr_data,
    output gutpc_pkg::t_cfg     o_cfg
);

    gutpc_pkg::t_cfg r_cfg;

    // register file, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gains_id  <= gutpc_pkg::RST_GAINS_ID;
            r_cfg.commit_id <= gutpc_pkg::RST_COMMIT_ID;
            r_cfg.version   <= gutpc_pkg::RST_VERSION;
            r_cfg.cookie    <= gutpc_pkg::RST_COOKIE;
            r_cfg.max_gain  <= gutpc_pkg::RST_MAX_GAIN;
            r_cfg.timeout   <= gutpc_pkg::RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_wr_idx)
                gutpc_pkg::CFG_GAINS_ID:  r_cfg.gains_id  <= i_cfg_wr_data[10:0];
                gutpc_pkg::CFG_COMMIT_ID: r_cfg.commit_id <= i_cfg_wr_data[10:0];
                gutpc_pkg::CFG_VERSION:   r_cfg.version   <= i_cfg_wr_data[7:0];
                gutpc_pkg::CFG_COOKIE:    r_cfg.cookie    <= i_cfg_wr_data;
                gutpc_pkg::CFG_MAX_GAIN:  r_cfg.max_gain  <= i_cfg_wr_data;
                gutpc_pkg::CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/gutpc_engine.sv =====
module gutpc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gutpc_pkg::t_cfg     i_cfg,
    input  logic                i_fire,
    input  gutpc_pkg::t_frame   i_frame,
    output gutpc_pkg::t_result  o_result
);

    // staged entry and committed gains
    logic                  r_staged_valid;
    logic [15:0]           r_staged_seq;
    logic [1:0]            r_staged_axes;
    logic [15:0]           r_staged_kp;
    logic [15:0]           r_staged_ki;
    logic [31:0]           r_staged_time;
    gutpc_pkg::t_gain_set  r_left;
    gutpc_pkg::t_gain_set  r_right;
    logic [15:0]           r_last_seq;
    logic [1:0]            r_last_axes;

    gutpc_pkg::t_gain_set  n_left;
    gutpc_pkg::t_gain_set  n_right;
    gutpc_pkg::t_gain_set  w_new_set;
    gutpc_pkg::t_status    w_status;

    logic [7:0]  w_version;
    logic [15:0] w_seq;
    logic [7:0]  w_axes;
    logic [15:0] w_half2;
    logic [15:0] w_half3;
    logic [31:0] w_age;
    logic        w_hdr_ok;
    logic        w_safe;
    logic        w_is_gains;
    logic        w_match;
    logic        w_late;
    logic        w_cookie_ok;
    logic        w_gain_ok;
    logic        w_stage;
    logic        w_accept;
    logic        w_clear;

    // field extraction
    assign w_version = i_frame.frame_bytes[7:0];
    assign w_seq     = i_frame.frame_bytes[23:8];
    assign w_axes    = i_frame.frame_bytes[31:24];
    assign w_half2   = i_frame.frame_bytes[47:32];
    assign w_half3   = i_frame.frame_bytes[63:48];

    // header check
    assign w_hdr_ok = (i_frame.frame_id == i_cfg.gains_id ||
                       i_frame.frame_id == i_cfg.commit_id) &&
                      i_frame.frame_length == gutpc_pkg::FRAME_LEN &&
                      !i_frame.extended_flag && !i_frame.remote_flag &&
                      w_version == i_cfg.version &&
                      (w_axes == gutpc_pkg::AXIS_LEFT || w_axes == gutpc_pkg::AXIS_RIGHT ||
                       w_axes == gutpc_pkg::AXIS_BOTH);

    assign w_safe = i_frame.motion_cmd_fresh && i_frame.motion_cmd_stop &&
                    i_frame.motion_cmd_zero && !i_frame.estop && !i_frame.fault;

    assign w_is_gains = (i_frame.frame_id == i_cfg.gains_id);

    // commit checks
    assign w_match     = r_staged_valid && r_staged_seq == w_seq &&
                         w_axes == {6'd0, r_staged_axes};
    assign w_age       = i_frame.time_ms - r_staged_time;
    assign w_late      = w_age > {16'd0, i_cfg.timeout};
    assign w_cookie_ok = (w_half3 == i_cfg.cookie);
    assign w_gain_ok   = r_staged_kp <= i_cfg.max_gain && r_staged_ki <= i_cfg.max_gain &&
                         w_half2 <= i_cfg.max_gain;

    // status in check order
    always_comb begin
        if (!w_hdr_ok) begin
            w_status = gutpc_pkg::ST_FORMAT;
        end else if (!w_safe) begin
            w_status = gutpc_pkg::ST_UNSAFE;
        end else if (w_is_gains) begin
            w_status = gutpc_pkg::ST_NONE;
        end else if (!w_match) begin
            w_status = gutpc_pkg::ST_FORMAT;
        end else if (w_late) begin
            w_status = gutpc_pkg::ST_TIMEOUT;
        end else if (!w_cookie_ok || !w_gain_ok) begin
            w_status = gutpc_pkg::ST_FORMAT;
        end else begin
            w_status = gutpc_pkg::ST_ACCEPT;
        end
    end

    assign w_stage  = w_hdr_ok && w_safe && w_is_gains;
    assign w_clear  = w_hdr_ok && !w_stage;
    assign w_accept = w_hdr_ok && w_safe && !w_is_gains && w_match && !w_late &&
                      w_cookie_ok && w_gain_ok;

    // gain set update
    always_comb begin
        w_new_set.kp = r_staged_kp;
        w_new_set.ki = r_staged_ki;
        w_new_set.kd = w_half2;
        n_left  = (w_accept && w_axes[0]) ? w_new_set : r_left;
        n_right = (w_accept && w_axes[1]) ? w_new_set : r_right;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_staged_valid <= 1'b0;
            r_staged_seq   <= '0;
            r_staged_axes  <= '0;
            r_staged_kp    <= '0;
            r_staged_ki    <= '0;
            r_staged_time  <= '0;
            r_left.kp      <= gutpc_pkg::RST_KP;
            r_left.ki      <= gutpc_pkg::RST_KI;
            r_left.kd      <= gutpc_pkg::RST_KD;
            r_right.kp     <= gutpc_pkg::RST_KP;
            r_right.ki     <= gutpc_pkg::RST_KI;
            r_right.kd     <= gutpc_pkg::RST_KD;
            r_last_seq     <= '0;
            r_last_axes    <= '0;
        end else if (i_fire) begin
            if (w_stage) begin
                r_staged_valid <= 1'b1;
                r_staged_seq   <= w_seq;
                r_staged_axes  <= w_axes[1:0];
                r_staged_kp    <= w_half2;
                r_staged_ki    <= w_half3;
                r_staged_time  <= i_frame.time_ms;
            end else if (w_clear) begin
                r_staged_valid <= 1'b0;
            end
            if (w_hdr_ok) begin
                r_last_seq  <= w_seq;
                r_last_axes <= w_axes[1:0];
            end
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    // result of this request
    always_comb begin
        o_result.status      = w_status;
        o_result.sequence_no = w_hdr_ok ? w_seq : r_last_seq;
        o_result.axes        = w_hdr_ok ? w_axes[1:0] : r_last_axes;
        o_result.left        = n_left;
        o_result.right       = n_right;
    end

`ifndef ASSERT_OFF
    a_accept_clears_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_accept |=> !r_staged_valid)
        else $error("staged entry survived an accepted commit");

    a_stage_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_stage |=> r_staged_valid && r_staged_time == $past(i_frame.time_ms))
        else $error("gains frame not staged");

    a_left_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_left != $past(r_left) |-> $past(i_fire && w_accept))
        else $error("left gains changed without accepted commit");

    a_right_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_right != $past(r_right) |-> $past(i_fire && w_accept))
        else $error("right gains changed without accepted commit");
`endif

endmodule
